// ===== hdl/rotated_tile_edge_match_top_defines.svh =====
// assertion macros for the rotated tile edge matcher
// used by the controller, no other dependencies
`ifndef ROTATED_TILE_EDGE_MATCH_TOP_DEFINES_SVH
`define ROTATED_TILE_EDGE_MATCH_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTEM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtem assertion failed");

// next-cycle implication, disabled in reset
`define RTEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtem assertion failed");

`endif

// ===== hdl/rtem_pkg.sv =====
// shared types and constants for the rotated tile edge matcher
// no dependencies
package rtem_pkg;

  localparam int TILE_COUNT  = 16;
  localparam int COLOR_COUNT = 31;
  localparam int SIDES       = 4;

  localparam int TILE_W  = 4;
  localparam int ROT_W   = 2;
  localparam int IDX_W   = TILE_W + ROT_W;
  localparam int COLOR_W = 5;
  localparam int EDGES_W = SIDES * COLOR_W;

  localparam logic [TILE_W:0]    TILE_LIMIT = (TILE_W + 1)'(TILE_COUNT);
  localparam logic [COLOR_W-1:0] WILDCARD   = COLOR_W'(COLOR_COUNT);
  localparam logic [IDX_W-1:0]   SCAN_LAST  = IDX_W'(TILE_COUNT * SIDES - 1);
  localparam logic [ROT_W-1:0]   ROT_LAST   = ROT_W'(SIDES - 1);

  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_QUERY_ALL = 2'd1;
  localparam logic [1:0] OP_QUERY_ID  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic write_tile;
    logic start;
    logic advance;
    logic take_cand;
    logic push_pend;
    logic push_last;
    logic push_cand;
    logic push_none;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       hit;
    logic       at_end;
    logic       mode_id;
    logic       pend_valid;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== hdl/rtem_if.sv =====
// handshake channel interfaces for the rotated tile edge matcher
// depends on rtem_pkg
interface rtem_in_if
  import rtem_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [TILE_W-1:0]  tile_slot;
  logic [COLOR_W-1:0] edge_one;
  logic [COLOR_W-1:0] edge_two;
  logic [COLOR_W-1:0] edge_three;
  logic [COLOR_W-1:0] edge_four;
  logic [COLOR_W-1:0] want_west;
  logic [COLOR_W-1:0] want_north;
  logic [COLOR_W-1:0] want_east;
  logic [COLOR_W-1:0] want_south;
  logic [TILE_W-1:0]  want_tile;

  modport source (
    output valid, op, tile_slot, edge_one, edge_two, edge_three, edge_four,
           want_west, want_north, want_east, want_south, want_tile,
    input  ready
  );
  modport sink (
    input  valid, op, tile_slot, edge_one, edge_two, edge_three, edge_four,
           want_west, want_north, want_east, want_south, want_tile,
    output ready
  );
endinterface

interface rtem_out_if
  import rtem_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [TILE_W-1:0]  tile_number;
  logic [ROT_W-1:0]   rotation;
  logic [IDX_W-1:0]   rotated_index;
  logic [COLOR_W-1:0] got_west;
  logic [COLOR_W-1:0] got_north;
  logic [COLOR_W-1:0] got_east;
  logic [COLOR_W-1:0] got_south;
  logic               last;

  modport source (
    output valid, found, tile_number, rotation, rotated_index,
           got_west, got_north, got_east, got_south, last,
    input  ready
  );
  modport sink (
    input  valid, found, tile_number, rotation, rotated_index,
           got_west, got_north, got_east, got_south, last,
    output ready
  );
endinterface

// ===== hdl/rtem_datapath.sv =====
// tile table, scan index, pending match and output register
// depends on rtem_pkg and rtem_if
module rtem_datapath
  import rtem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  st,
  rtem_in_if.sink     in_chan,
  rtem_out_if.source  out_chan
);

  logic [EDGES_W-1:0]    tile_edges_r [TILE_COUNT];
  logic [TILE_COUNT-1:0] tile_loaded_r;

  logic                  mode_id_r;
  logic [COLOR_W-1:0]    want_r [SIDES];
  logic [IDX_W-1:0]      idx_r;

  logic                  pend_valid_r;
  logic [IDX_W-1:0]      pend_idx_r;
  logic [COLOR_W-1:0]    pend_got_r [SIDES];

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [COLOR_W-1:0]    out_got_r [SIDES];
  logic                  out_last_r;

  logic [TILE_W-1:0]     cand_tile;
  logic [ROT_W-1:0]      cand_rot;
  logic                  cand_in_range;
  logic [EDGES_W-1:0]    cand_edges;
  logic [COLOR_W-1:0]    cand_got [SIDES];
  logic                  cand_ok;
  logic                  slot_in_range;

  assign cand_tile     = idx_r[IDX_W-1:ROT_W];
  assign cand_rot      = idx_r[ROT_W-1:0];
  assign cand_in_range = {1'b0, cand_tile} < TILE_LIMIT;
  assign cand_edges    = tile_edges_r[cand_tile];
  assign slot_in_range = {1'b0, in_chan.tile_slot} < TILE_LIMIT;

  // rotation k puts edge (s - k) mod 4 on side s
  always_comb begin
    logic [ROT_W-1:0] src;
    cand_ok = cand_in_range && tile_loaded_r[cand_tile];
    for (int s = 0; s < SIDES; s++) begin
      src         = ROT_W'(s) - cand_rot;
      cand_got[s] = cand_edges[src*COLOR_W +: COLOR_W];
      if (!(cand_got[s] == want_r[s] || want_r[s] == WILDCARD)) begin
        cand_ok = 1'b0;
      end
    end
  end

  // tile table
  always_ff @(posedge clk) begin
    if (cmd.write_tile && slot_in_range) begin
      tile_edges_r[in_chan.tile_slot] <= {in_chan.edge_four, in_chan.edge_three,
                                          in_chan.edge_two, in_chan.edge_one};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_loaded_r <= '0;
    end else if (cmd.write_tile && slot_in_range) begin
      tile_loaded_r[in_chan.tile_slot] <= 1'b1;
    end
  end

  // query registers and scan index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_id_r <= (in_chan.op == OP_QUERY_ID);
      want_r[0] <= in_chan.want_west;
      want_r[1] <= in_chan.want_north;
      want_r[2] <= in_chan.want_east;
      want_r[3] <= in_chan.want_south;
      idx_r     <= (in_chan.op == OP_QUERY_ID) ? {in_chan.want_tile, ROT_W'(0)} : '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // pending match, held until the next match or the end of the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.start) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.take_cand) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.push_pend && cmd.push_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_cand) begin
      pend_idx_r <= idx_r;
      pend_got_r <= cand_got;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_pend || cmd.push_cand || cmd.push_none) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pend) begin
      out_found_r <= 1'b1;
      out_idx_r   <= pend_idx_r;
      out_got_r   <= pend_got_r;
      out_last_r  <= cmd.push_last;
    end else if (cmd.push_cand) begin
      out_found_r <= 1'b1;
      out_idx_r   <= idx_r;
      out_got_r   <= cand_got;
      out_last_r  <= 1'b1;
    end else if (cmd.push_none) begin
      out_found_r <= 1'b0;
      out_idx_r   <= '0;
      for (int s = 0; s < SIDES; s++) begin
        out_got_r[s] <= '0;
      end
      out_last_r  <= 1'b1;
    end
  end

  assign in_chan.ready          = cmd.accept;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.tile_number   = out_idx_r[IDX_W-1:ROT_W];
  assign out_chan.rotation      = out_idx_r[ROT_W-1:0];
  assign out_chan.rotated_index = out_idx_r;
  assign out_chan.got_west      = out_got_r[0];
  assign out_chan.got_north     = out_got_r[1];
  assign out_chan.got_east      = out_got_r[2];
  assign out_chan.got_south     = out_got_r[3];
  assign out_chan.last          = out_last_r;

  assign st.in_valid   = in_chan.valid;
  assign st.in_op      = in_chan.op;
  assign st.hit        = cand_ok;
  assign st.at_end     = mode_id_r ? (cand_rot == ROT_LAST) : (idx_r == SCAN_LAST);
  assign st.mode_id    = mode_id_r;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = !out_valid_r || out_chan.ready;

endmodule

// ===== hdl/rtem_ctrl.sv =====
// scan controller state machine for the rotated tile edge matcher
// depends on rtem_pkg and the assertion macro header
`include "rotated_tile_edge_match_top_defines.svh"

module rtem_ctrl
  import rtem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = 1'b1;
        if (st.in_valid) begin
          unique case (st.in_op) inside
            OP_LOAD: cmd.write_tile = 1'b1;
            OP_QUERY_ALL, OP_QUERY_ID: begin
              cmd.start = 1'b1;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (st.hit && st.mode_id) begin
          // first match of the wanted tile ends the query
          if (st.out_free) begin
            cmd.push_cand = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (st.hit && st.pend_valid) begin
          if (st.out_free) begin
            cmd.push_pend = 1'b1;
            cmd.take_cand = 1'b1;
            cmd.advance   = 1'b1;
            if (st.at_end) begin
              state_nxt = ST_FLUSH;
            end
          end
        end else begin
          cmd.take_cand = st.hit;
          cmd.advance   = 1'b1;
          if (st.at_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (st.out_free) begin
          cmd.push_pend = st.pend_valid;
          cmd.push_last = st.pend_valid;
          cmd.push_none = !st.pend_valid;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [2:0] push_vec;
  logic       push_any;

  assign push_vec = {cmd.push_pend, cmd.push_cand, cmd.push_none};
  assign push_any = |push_vec;

  `RTEM_ASSERT_IMPL(a_push_needs_room, clk, rst_n, push_any, st.out_free)
  `RTEM_ASSERT_IMPL(a_single_push, clk, rst_n, 1'b1, $onehot0(push_vec))
  `RTEM_ASSERT_IMPL(a_pending_kept, clk, rst_n, cmd.take_cand && st.pend_valid, cmd.push_pend)
  `RTEM_ASSERT_NEXT(a_flush_ends_query, clk, rst_n, state_r == ST_FLUSH && st.out_free, state_r == ST_IDLE)

endmodule

// ===== hdl/rotated_tile_edge_match_top.sv =====
// top level of the rotated tile edge matcher
// depends on rtem_pkg, rtem_if, rtem_ctrl and rtem_datapath

// Holds 16 tiles of four 5-bit edge colours and answers queries on them. Once a
// query is accepted, the controller walks the register table one rotated tile
// per cycle while the scan is not waiting: all 64 rotated tiles for a query of
// all matches, at most 4 for a query of one tile id, then it delivers the final
// result. A query of all matches sends every match as a transaction of its own,
// the last one marked; a query of one tile id sends only its first match, marked
// last. A query with no match gives a single transaction with found clear. A new
// transaction is taken only when the previous query has ended; the scan waits
// whenever a result is ready and the output register is still held.
module rotated_tile_edge_match_top
  import rtem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rtem_in_if.sink    in_chan,
  rtem_out_if.source out_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  rtem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  rtem_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
